// ===== rtl/scc_pkg.sv =====
package scc_pkg;

    localparam int NUM_LINES_DEF   = 64;
    localparam int SECTOR_BITS_DEF = 32;
    localparam int MODE_W          = 3;

    localparam logic [MODE_W-1:0] MODE_READ      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PREFETCH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH_INV = 3'd4;

    typedef struct packed {
        logic load;
        logic look_step;
        logic em_hit;
        logic take_free;
        logic evict_init;
        logic evict_step;
        logic em_fill;
        logic f_mark;
        logic f_step;
        logic f_push;
        logic f_finish;
    } t_cmd;

    typedef struct packed {
        logic in_access;
        logic in_flush;
        logic hit;
        logic miss_done;
        logic full;
        logic acc_set;
        logic scan_end;
        logic cur_dirty;
        logic pend_valid;
        logic emit_ok;
    } t_stat;

endpackage

// ===== rtl/sector_cache_clock_replacement_core.sv =====
// Tag and replacement controller for a fully associative sector cache.
// The input channel (i_in_valid, o_in_stall) carries one beat per command:
// read, write or prefetch of a sector, flush of dirty lines, or flush with
// invalidate. The output channel (o_out_valid, i_out_stall) carries result
// beats: one for each access or prefetch, one per dirty line for a flush,
// with o_last on the final beat of a command. Undefined modes give none.
// One command is worked on at a time. A lookup compares one stored tag per
// cycle against the sector. A miss on a full cache adds a second chance
// scan from slot 0 that clears the accessed bit of each line it passes
// over. A flush steps over clean lines and marks each dirty line clean
// before it queues that line's result beat. The tag memory read port is
// registered. The result register lets the next command be accepted while
// a result beat still waits. While i_out_stall holds, the beat stays
// unchanged and the controller waits before writing another one.
// Synchronous reset empties the cache: no lines in use, all dirty and
// accessed bits clear. No clearing pass is needed.
module sector_cache_clock_replacement_core #(
    parameter int NUM_LINES   = scc_pkg::NUM_LINES_DEF,
    parameter int SECTOR_BITS = scc_pkg::SECTOR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [scc_pkg::MODE_W-1:0]    i_mode,
    input  logic [SECTOR_BITS-1:0]        i_sector,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [$clog2(NUM_LINES)-1:0]  o_slot,
    output logic                          o_hit,
    output logic                          o_fill_needed,
    output logic                          o_writeback_valid,
    output logic [SECTOR_BITS-1:0]        o_writeback_sector,
    output logic                          o_last
);

    scc_pkg::t_cmd  cmd;
    scc_pkg::t_stat stat;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scc_dp #(
        .NUM_LINES   (NUM_LINES),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_mode             (i_mode),
        .i_sector           (i_sector),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_slot             (o_slot),
        .o_hit              (o_hit),
        .o_fill_needed      (o_fill_needed),
        .o_writeback_valid  (o_writeback_valid),
        .o_writeback_sector (o_writeback_sector),
        .o_last             (o_last)
    );

endmodule

// ===== rtl/scc_dp.sv =====
module scc_dp #(
    parameter int NUM_LINES   = scc_pkg::NUM_LINES_DEF,
    parameter int SECTOR_BITS = scc_pkg::SECTOR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [scc_pkg::MODE_W-1:0]          i_mode,
    input  logic [SECTOR_BITS-1:0]              i_sector,
    input  scc_pkg::t_cmd                       i_cmd,
    output scc_pkg::t_stat                      o_stat,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [$clog2(NUM_LINES)-1:0]        o_slot,
    output logic                                o_hit,
    output logic                                o_fill_needed,
    output logic                                o_writeback_valid,
    output logic [SECTOR_BITS-1:0]              o_writeback_sector,
    output logic                                o_last
);

    localparam int SLOT_W = $clog2(NUM_LINES);
    localparam int IDX_W  = $clog2(NUM_LINES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LINES - 1);
    localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(NUM_LINES);

    logic [scc_pkg::MODE_W-1:0] r_mode;
    logic [SECTOR_BITS-1:0]     r_sector;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_filled;
    logic                       r_cmp_valid;
    logic [SLOT_W-1:0]          r_cmp_idx;
    logic [SECTOR_BITS-1:0]     r_tag_q;
    logic [SECTOR_BITS-1:0]     r_tag_mem [NUM_LINES];
    logic [NUM_LINES-1:0]       r_dirty;
    logic [NUM_LINES-1:0]       r_acc;
    logic                       r_pend_valid;
    logic [SLOT_W-1:0]          r_pend_slot;
    logic [SECTOR_BITS-1:0]     r_pend_tag;

    logic                       r_out_valid;
    logic [SLOT_W-1:0]          r_out_slot;
    logic                       r_out_hit;
    logic                       r_out_fill;
    logic                       r_out_wbv;
    logic [SECTOR_BITS-1:0]     r_out_wbs;
    logic                       r_out_last;

    logic                       n_emit;
    logic [SLOT_W-1:0]          n_slot;
    logic                       n_hit;
    logic                       n_fill;
    logic                       n_wbv;
    logic [SECTOR_BITS-1:0]     n_wbs;
    logic                       n_last;

    logic [SLOT_W-1:0]          cur;
    logic                       issue;
    logic                       tag_match;
    logic                       emit_ok;

    assign cur       = r_idx[SLOT_W-1:0];
    assign issue     = r_idx < r_filled;
    assign tag_match = r_cmp_valid && (r_tag_q == r_sector);
    assign emit_ok   = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.in_access  = (i_mode == scc_pkg::MODE_READ) || (i_mode == scc_pkg::MODE_WRITE)
                            || (i_mode == scc_pkg::MODE_PREFETCH);
        o_stat.in_flush   = (i_mode == scc_pkg::MODE_FLUSH)
                            || (i_mode == scc_pkg::MODE_FLUSH_INV);
        o_stat.hit        = tag_match;
        o_stat.miss_done  = !r_cmp_valid && !issue;
        o_stat.full       = r_filled == FULL_CNT;
        o_stat.acc_set    = r_acc[cur];
        o_stat.scan_end   = !issue;
        o_stat.cur_dirty  = r_dirty[cur];
        o_stat.pend_valid = r_pend_valid;
        o_stat.emit_ok    = emit_ok;
    end

    always_comb begin
        n_emit = 1'b0;
        n_slot = r_pend_slot;
        n_hit  = 1'b0;
        n_fill = 1'b0;
        n_wbv  = 1'b1;
        n_wbs  = r_pend_tag;
        n_last = 1'b0;
        priority if (i_cmd.em_hit) begin
            n_emit = 1'b1;
            n_slot = r_cmp_idx;
            n_hit  = 1'b1;
            n_wbv  = 1'b0;
            n_wbs  = '0;
            n_last = 1'b1;
        end else if (i_cmd.em_fill) begin
            n_emit = 1'b1;
            n_slot = cur;
            n_fill = 1'b1;
            n_wbv  = r_dirty[cur];
            n_wbs  = r_dirty[cur] ? r_tag_q : '0;
            n_last = 1'b1;
        end else if (i_cmd.f_push) begin
            n_emit = r_pend_valid;
        end else if (i_cmd.f_finish) begin
            n_emit = r_pend_valid;
            n_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.em_fill) begin
            r_tag_mem[cur] <= r_sector;
        end
        r_tag_q <= r_tag_mem[cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled     <= '0;
            r_dirty      <= '0;
            r_acc        <= '0;
            r_cmp_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mode       <= i_mode;
                r_sector     <= i_sector;
                r_idx        <= '0;
                r_cmp_valid  <= 1'b0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.look_step) begin
                r_cmp_valid <= issue;
                r_cmp_idx   <= cur;
                if (issue) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (i_cmd.em_hit && (r_mode != scc_pkg::MODE_PREFETCH)) begin
                r_acc[r_cmp_idx] <= 1'b1;
                if (r_mode == scc_pkg::MODE_WRITE) begin
                    r_dirty[r_cmp_idx] <= 1'b1;
                end
            end
            if (i_cmd.take_free) begin
                r_idx    <= r_filled;
                r_filled <= r_filled + IDX_W'(1);
            end
            if (i_cmd.evict_init) begin
                r_idx <= '0;
            end
            if (i_cmd.evict_step) begin
                r_acc[cur] <= 1'b0;
                r_idx      <= (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
            end
            if (i_cmd.em_fill) begin
                r_dirty[cur] <= r_mode == scc_pkg::MODE_WRITE;
                r_acc[cur]   <= r_mode != scc_pkg::MODE_PREFETCH;
            end
            if (i_cmd.f_mark) begin
                r_dirty[cur] <= 1'b0;
            end
            if (i_cmd.f_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.f_push) begin
                r_pend_valid <= 1'b1;
                r_pend_slot  <= cur;
                r_pend_tag   <= r_tag_q;
                r_idx        <= r_idx + IDX_W'(1);
            end
            if (i_cmd.f_finish) begin
                r_pend_valid <= 1'b0;
                if (r_mode == scc_pkg::MODE_FLUSH_INV) begin
                    r_dirty  <= '0;
                    r_acc    <= '0;
                    r_filled <= '0;
                end
            end
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_out_slot <= n_slot;
            r_out_hit  <= n_hit;
            r_out_fill <= n_fill;
            r_out_wbv  <= n_wbv;
            r_out_wbs  <= n_wbs;
            r_out_last <= n_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_slot             = r_out_slot;
    assign o_hit              = r_out_hit;
    assign o_fill_needed      = r_out_fill;
    assign o_writeback_valid  = r_out_wbv;
    assign o_writeback_sector = r_out_wbs;
    assign o_last             = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FULL_CNT)
        else $error("fill count beyond line count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_emit |-> emit_ok)
        else $error("result written over a waiting beat");

    a_hit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.em_hit |-> (r_cmp_valid && (r_tag_mem[r_cmp_idx] == r_sector)))
        else $error("hit reported without a tag match");

    a_inv_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.f_finish && (r_mode == scc_pkg::MODE_FLUSH_INV)) |=> (r_filled == '0))
        else $error("invalidate left lines in use");

endmodule

// ===== rtl/scc_ctrl.sv =====
module scc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  scc_pkg::t_stat i_stat,
    output scc_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOKUP = 4'd1;
    localparam logic [3:0] S_HIT    = 4'd2;
    localparam logic [3:0] S_MISS   = 4'd3;
    localparam logic [3:0] S_EVICT  = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_FSCAN  = 4'd6;
    localparam logic [3:0] S_FHOLD  = 4'd7;
    localparam logic [3:0] S_FEND   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_access) begin
                        n_state = S_LOOKUP;
                    end else if (i_stat.in_flush) begin
                        n_state = S_FSCAN;
                    end
                end
            end
            S_LOOKUP: begin
                if (i_stat.hit) begin
                    n_state = S_HIT;
                end else if (i_stat.miss_done) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.look_step = 1'b1;
                end
            end
            S_HIT: begin
                if (i_stat.emit_ok) begin
                    o_cmd.em_hit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MISS: begin
                if (i_stat.full) begin
                    o_cmd.evict_init = 1'b1;
                    n_state          = S_EVICT;
                end else begin
                    o_cmd.take_free = 1'b1;
                    n_state         = S_FILL;
                end
            end
            S_EVICT: begin
                if (i_stat.acc_set) begin
                    o_cmd.evict_step = 1'b1;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_stat.emit_ok) begin
                    o_cmd.em_fill = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_FEND;
                end else if (i_stat.cur_dirty) begin
                    o_cmd.f_mark = 1'b1;
                    n_state      = S_FHOLD;
                end else begin
                    o_cmd.f_step = 1'b1;
                end
            end
            S_FHOLD: begin
                if (!i_stat.pend_valid || i_stat.emit_ok) begin
                    o_cmd.f_push = 1'b1;
                    n_state      = S_FSCAN;
                end
            end
            S_FEND: begin
                if (!i_stat.pend_valid || i_stat.emit_ok) begin
                    o_cmd.f_finish = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("new item loaded while busy");

endmodule
